>>> hdl/brake_stability_frame_generator_top_defines.svh
// Assertion macros for the brake/stability frame generator.
// Used by the top level; relies on signals clk and rst_n in the including scope.
`ifndef BRAKE_STABILITY_FRAME_GENERATOR_TOP_DEFINES_SVH
`define BRAKE_STABILITY_FRAME_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BSFG_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("bsfg assertion failed");
`define BSFG_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("bsfg assertion failed");
`else
`define BSFG_ASSERT_IMP(lbl, ant, cons)
`define BSFG_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

>>> hdl/bsfg_pkg.sv
// Package for the brake/stability frame generator: field widths, frame
// constants, item and frame types, and the checksum fold. No dependencies.
`default_nettype none
package bsfg_pkg;

  localparam int SPEED_W   = 14;
  localparam int GEAR_W    = 8;
  localparam int ID_W      = 11;
  localparam int LEN_W     = 4;
  localparam int WORD_W    = 32;
  localparam int PHASE_W   = 4;
  localparam int SUM_W     = 12;

  localparam logic [ID_W-1:0]  ID_AA = 11'h0AA;
  localparam logic [ID_W-1:0]  ID_A8 = 11'h0A8;
  localparam logic [ID_W-1:0]  ID_A9 = 11'h0A9;
  localparam logic [ID_W-1:0]  ID_BA = 11'h0BA;

  localparam logic [LEN_W-1:0] LEN_FULL  = 4'd8;
  localparam logic [LEN_W-1:0] LEN_SHORT = 4'd7;

  localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd14;

  localparam logic [SPEED_W-1:0] IDLE_RPM = 14'd750;

  localparam logic [7:0] BRAKE_ON_BYTE  = 8'h64;
  localparam logic [7:0] BRAKE_OFF_BYTE = 8'h04;
  localparam logic [3:0] CNT_HI_READY   = 4'h5;
  localparam logic [3:0] CNT_HI_IDLE    = 4'h3;
  localparam logic [7:0] AA_B2_READY    = 8'h07;
  localparam logic [7:0] AA_B2_IDLE     = 8'hFE;
  localparam logic [7:0] AA_B6_READY    = 8'h94;
  localparam logic [7:0] AA_B6_IDLE     = 8'h84;
  localparam logic [7:0] A9_CHK_BASE    = 8'hE9;
  localparam logic [7:0] BA_CNT_BASE    = 8'h80;

  typedef enum logic [1:0] {
    FRM_AA,
    FRM_A8,
    FRM_A9,
    FRM_BA
  } frame_sel_t;

  typedef struct packed {
    logic               brake_on;
    logic               drive_ready;
    logic [SPEED_W-1:0] motor_speed;
    logic [GEAR_W-1:0]  gear_code;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_length;
    logic [WORD_W-1:0] payload_low;
    logic [WORD_W-1:0] payload_high;
    logic              last_frame;
  } frame_t;

  // Byte sum with the carry out of the low byte added back once.
  function automatic logic [7:0] fold_sum(input logic [SUM_W-1:0] s);
    logic [7:0] r;
    r = 8'({4'h0, s[SUM_W-1:8]} + s[7:0]);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/bsfg_if.sv
// Channel interfaces of the frame generator: tick input and frame output.
// Depends on bsfg_pkg for field widths.
`default_nettype none
interface bsfg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          brake_on;
  logic                          drive_ready;
  logic [bsfg_pkg::SPEED_W-1:0]  motor_speed;
  logic [bsfg_pkg::GEAR_W-1:0]   gear_code;

  modport source (output valid, brake_on, drive_ready, motor_speed, gear_code,
                  input ready);
  modport sink   (input valid, brake_on, drive_ready, motor_speed, gear_code,
                  output ready);
endinterface

interface bsfg_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsfg_pkg::ID_W-1:0]     frame_id;
  logic [bsfg_pkg::LEN_W-1:0]    frame_length;
  logic [bsfg_pkg::WORD_W-1:0]   payload_low;
  logic [bsfg_pkg::WORD_W-1:0]   payload_high;
  logic                          last_frame;

  modport source (output valid, frame_id, frame_length, payload_low, payload_high,
                  last_frame, input ready);
  modport sink   (input valid, frame_id, frame_length, payload_low, payload_high,
                  last_frame, output ready);
endinterface
`default_nettype wire

>>> hdl/brake_stability_frame_generator_top.sv
// Top level of the brake/stability frame generator: tick register, phase
// counter, frame sequencing and output stage. Depends on bsfg_pkg, bsfg_if,
// bsfg_frame_build, bsfg_out_stage and the assertion macro header.
//
// Usage: each beat on in_ch is one 10 ms tick (brake flag, drive-ready flag,
// motor speed, gear code). For every tick the block sends four beats on
// out_ch in fixed order: frames 0x0AA, 0x0A8, 0x0A9 and 0x0BA, the last one
// flagged with last_frame. All rolling counters come from one phase counter
// that runs 0 to 14 and advances once per accepted tick.
// The tick beat is held in the tick register and each frame then passes
// through the output register to out_ch. The single frame output port
// carries one frame per cycle while the receiver does not stall. A new tick
// is accepted in the cycle that the fourth frame of the previous tick moves
// into the output register, so ticks can run back to back.
// Reset (synchronous, rst_n low) empties the tick register and the output
// register and sets the phase to zero.
// When the receiver stalls, the pending frame holds in the output register,
// frame sequencing pauses and in_ch.ready drops once a tick is waiting.
`default_nettype none
`include "brake_stability_frame_generator_top_defines.svh"
module brake_stability_frame_generator_top (
  input  logic       clk,
  input  logic       rst_n,
  bsfg_in_if.sink    in_ch,
  bsfg_out_if.source out_ch
);
  import bsfg_pkg::*;

  logic                 hold_valid_r, hold_valid_nxt;
  item_t                item_r;
  logic [PHASE_W-1:0]   item_phase_r;
  frame_sel_t           sel_r, sel_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;

  logic                 in_accept;
  logic                 advance;
  logic                 stage_ready;
  logic                 tick_done;
  frame_t               frame;

  // A frame moves to the output register whenever the register can take it.
  assign advance   = hold_valid_r && stage_ready;
  assign tick_done = advance && (sel_r == FRM_BA);
  assign in_ch.ready = !hold_valid_r || tick_done;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // The phase wraps after 14; an out-of-range 15 also wraps to zero.
  assign phase_nxt = !in_accept ? phase_r
                   : (phase_r >= PHASE_LAST) ? '0
                   : phase_r + 1'b1;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    sel_nxt        = sel_r;
    if (in_accept) begin
      hold_valid_nxt = 1'b1;
      sel_nxt        = FRM_AA;
    end else if (advance) begin
      unique case (sel_r)
        FRM_AA:  sel_nxt = FRM_A8;
        FRM_A8:  sel_nxt = FRM_A9;
        FRM_A9:  sel_nxt = FRM_BA;
        FRM_BA: begin
          sel_nxt        = FRM_AA;
          hold_valid_nxt = 1'b0;
        end
        default: sel_nxt = FRM_AA;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      sel_r        <= FRM_AA;
      phase_r      <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      sel_r        <= sel_nxt;
      phase_r      <= phase_nxt;
    end
  end

  // The tick payload and the phase it uses are captured together.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.brake_on    <= in_ch.brake_on;
      item_r.drive_ready <= in_ch.drive_ready;
      item_r.motor_speed <= in_ch.motor_speed;
      item_r.gear_code   <= in_ch.gear_code;
      item_phase_r       <= phase_r;
    end
  end

  bsfg_frame_build u_build (
    .item  (item_r),
    .phase (item_phase_r),
    .sel   (sel_r),
    .frame (frame)
  );

  bsfg_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (hold_valid_r),
    .load_frame (frame),
    .load_ready (stage_ready),
    .out_ch     (out_ch)
  );

  // No new tick while frames of the current one remain to be sent.
  `BSFG_ASSERT_IMP(a_no_early_accept, hold_valid_r && (sel_r != FRM_BA), !in_ch.ready)
  // An accepted tick starts its sequence at the first frame.
  `BSFG_ASSERT_NXT(a_tick_starts, in_accept, hold_valid_r && (sel_r == FRM_AA))
  // The last-frame flag only ever travels with frame 0x0BA.
  `BSFG_ASSERT_IMP(a_last_is_ba, out_ch.valid && out_ch.last_frame, out_ch.frame_id == ID_BA)
  // The phase counter never leaves its 0 to 14 range.
  `BSFG_ASSERT_IMP(a_phase_range, 1'b1, phase_r <= PHASE_LAST)

endmodule
`default_nettype wire

>>> hdl/bsfg_frame_build.sv
// Combinational frame assembly: one of the four frames of a tick from the
// held item, its phase and the frame select. Depends on bsfg_pkg.
`default_nettype none
module bsfg_frame_build (
  input  bsfg_pkg::item_t               item,
  input  logic [bsfg_pkg::PHASE_W-1:0]  phase,
  input  bsfg_pkg::frame_sel_t          sel,
  output bsfg_pkg::frame_t              frame
);
  import bsfg_pkg::*;

  logic [SPEED_W-1:0] speed_floor;
  logic [15:0]        rpm;
  logic [7:0]         aa_b1, aa_b2, aa_b6, aa_chk;
  logic [7:0]         a8_b7, a8_chk;
  logic [7:0]         ba_b6, ba_chk;

  // A 14-bit speed times four always fits in 16 bits, so no saturation is needed.
  assign speed_floor = (item.motor_speed > IDLE_RPM) ? item.motor_speed : IDLE_RPM;
  assign rpm   = item.drive_ready ? {speed_floor, 2'b00} : 16'h0000;
  assign aa_b1 = {item.drive_ready ? CNT_HI_READY : CNT_HI_IDLE, phase};
  assign aa_b2 = item.drive_ready ? AA_B2_READY : AA_B2_IDLE;
  assign aa_b6 = item.drive_ready ? AA_B6_READY : AA_B6_IDLE;
  assign aa_chk = fold_sum(SUM_W'(ID_AA[7:0]) + SUM_W'(aa_b1) + SUM_W'(aa_b2)
                           + SUM_W'(rpm[7:0]) + SUM_W'(rpm[15:8]) + SUM_W'(aa_b6));

  assign a8_b7  = item.brake_on ? BRAKE_ON_BYTE : BRAKE_OFF_BYTE;
  assign a8_chk = fold_sum(SUM_W'(ID_A8[7:0]) + SUM_W'(phase) + SUM_W'(8'h21)
                           + SUM_W'(8'hE0) + SUM_W'(8'h21) + SUM_W'(8'h1F)
                           + SUM_W'(8'h0F) + SUM_W'(a8_b7));

  assign ba_b6  = BA_CNT_BASE + {4'h0, phase};
  assign ba_chk = fold_sum(SUM_W'(item.gear_code) + SUM_W'(8'hFF) + SUM_W'(8'h0F)
                           + SUM_W'(ba_b6) + SUM_W'(ID_BA[7:0]));

  always_comb begin
    frame = '0;
    unique case (sel)
      FRM_AA: begin
        frame.frame_id     = ID_AA;
        frame.frame_length = LEN_FULL;
        frame.payload_low  = {8'h00, aa_b2, aa_b1, aa_chk};
        frame.payload_high = {8'h00, aa_b6, rpm[15:8], rpm[7:0]};
        frame.last_frame   = 1'b0;
      end
      FRM_A8: begin
        frame.frame_id     = ID_A8;
        frame.frame_length = LEN_FULL;
        frame.payload_low  = {8'hE0, 8'h21, {4'h0, phase}, a8_chk};
        frame.payload_high = {a8_b7, 8'h0F, 8'h1F, 8'h21};
        frame.last_frame   = 1'b0;
      end
      FRM_A9: begin
        frame.frame_id     = ID_A9;
        frame.frame_length = LEN_FULL;
        frame.payload_low  = {8'hDF, 8'h79, {4'h0, phase}, A9_CHK_BASE + {4'h0, phase}};
        frame.payload_high = {8'h21, 8'hE0, 8'hC7, 8'h1D};
        frame.last_frame   = 1'b0;
      end
      FRM_BA: begin
        frame.frame_id     = ID_BA;
        frame.frame_length = LEN_SHORT;
        frame.payload_low  = {8'h00, 8'h0F, 8'hFF, item.gear_code};
        frame.payload_high = {8'h00, ba_b6, ba_chk, 8'h00};
        frame.last_frame   = 1'b1;
      end
      default: frame = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/bsfg_out_stage.sv
// Output register of the frame generator: holds one frame beat until the
// receiver takes it. Depends on bsfg_pkg and bsfg_out_if.
`default_nettype none
module bsfg_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_valid,
  input  bsfg_pkg::frame_t  load_frame,
  output logic              load_ready,
  bsfg_out_if.source        out_ch
);
  import bsfg_pkg::*;

  logic   valid_r, valid_nxt;
  frame_t frame_r;

  assign load_ready = !valid_r || out_ch.ready;
  assign valid_nxt  = load_ready ? load_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      frame_r <= load_frame;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.frame_id     = frame_r.frame_id;
  assign out_ch.frame_length = frame_r.frame_length;
  assign out_ch.payload_low  = frame_r.payload_low;
  assign out_ch.payload_high = frame_r.payload_high;
  assign out_ch.last_frame   = frame_r.last_frame;

endmodule
`default_nettype wire
